// ----- hdl/psl_pkg.sv -----
// ---------------------------------------------------------------------------
// psl_pkg: shared types and constants for the positional sequential list
// Sizes of the entry store, field widths, action codes and the control
// word that the list controller broadcasts to the row of entry cells.
// ---------------------------------------------------------------------------
package psl_pkg;

   // Store depth and the widths derived from it.
   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);

   // Fixed field widths of the beats.
   localparam int ACTION_W = 2;
   localparam int POS_W    = 4;
   localparam int WORD_W   = 32;
   localparam int CNT_W    = 5;
   localparam int CAP_W    = 5;

   // Packed payload widths, rounded up to whole bytes.
   localparam int REQ_BITS   = ACTION_W + POS_W + WORD_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 1 + WORD_W + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(LIST_DEPTH);

   // Requested operation.
   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_GET    = 2'd1,
      ACT_POP    = 2'd2,
      ACT_CLEAR  = 2'd3
   } psl_action_type;

   // Movement of the entry row.
   typedef enum logic [1:0] {
      SHIFT_HOLD   = 2'd0,
      SHIFT_INSERT = 2'd1,
      SHIFT_POP    = 2'd2
   } psl_shift_type;

   // Control word shared by every cell of the row.
   typedef struct packed {
      psl_shift_type     shift;
      logic [IDX_W-1:0]  pos;
      logic [WORD_W-1:0] word;
   } psl_ctrl_type;

endpackage

// ----- hdl/psl_cell.sv -----
// ---------------------------------------------------------------------------
// psl_cell: one entry cell of the list row
// Holds one word. On an insert it loads the new word at the target position
// or takes its lower neighbour's word above it; on a pop it takes its upper
// neighbour's word at and above the target position.
// ---------------------------------------------------------------------------
module psl_cell (
   input  logic                          clock,
   input  logic [psl_pkg::IDX_W-1:0]     cell_index,
   input  psl_pkg::psl_ctrl_type         ctrl,
   input  logic [psl_pkg::WORD_W-1:0]    lower_word,
   input  logic [psl_pkg::WORD_W-1:0]    upper_word,
   output logic [psl_pkg::WORD_W-1:0]    word_out
);
   import psl_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   // Select the next content from the broadcast movement.
   always_comb begin
      word_in = word_ff;
      unique case (ctrl.shift)
         SHIFT_INSERT: begin
            if (cell_index == ctrl.pos) begin
               word_in = ctrl.word;
            end else if (cell_index > ctrl.pos) begin
               word_in = lower_word;
            end
         end
         SHIFT_POP: begin
            if (cell_index >= ctrl.pos) begin
               word_in = upper_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // Entry storage carries no reset: unwritten cells are never read.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

// ----- hdl/positional_sequential_list_top.sv -----
// ---------------------------------------------------------------------------
// positional_sequential_list_top: ordered list of words in a row of cells
// Request beats carry an action (insert, get, pop, clear), a position and a
// word; each request yields exactly one response beat.
//
// Usage:
//   The req_ channel takes one action per beat; the rsp_ channel returns
//   the success flag, a data word and the entry count after the action.
//   The csr_ channel writes the list capacity (5 bits); it is always ready
//   and is meant to be written only while no request is outstanding.
//   All cells of the row shift up or down together, so an insert or pop at
//   any position costs the same. The response is registered and appears in
//   the cycle after the request beat is taken, and a new request is taken in
//   every cycle that the response register is empty or being drained,
//   giving one beat per cycle.
//   When the receiver holds rsp_tready low the response is held and
//   req_tready drops until the beat is taken.
//   Synchronous reset empties the list, clears the last popped word to zero
//   and sets the capacity to 16. No clearing pass follows reset; the block
//   accepts requests in the first cycle after reset.
// ---------------------------------------------------------------------------
module positional_sequential_list_top (
   input  logic                              clock,
   input  logic                              reset,
   // Request: [1:0] action, [5:2] position, [37:6] value, [39:38] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Response: [0] ok, [32:1] data, [37:33] count, [39:38] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Capacity write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psl_pkg::CAP_W-1:0]         csr_data
);
   import psl_pkg::*;

   // Request fields.
   psl_action_type     req_action;
   logic [POS_W-1:0]   req_position;
   logic [WORD_W-1:0]  req_value;

   assign req_action   = psl_action_type'(req_tdata[ACTION_W-1:0]);
   assign req_position = req_tdata[ACTION_W+POS_W-1:ACTION_W];
   assign req_value    = req_tdata[REQ_BITS-1:ACTION_W+POS_W];

   // Control state.
   logic [CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [WORD_W-1:0] last_popped_ff;
   logic [WORD_W-1:0] last_popped_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_ok_ff;
   logic              rsp_ok_in;
   logic [WORD_W-1:0] rsp_data_ff;
   logic [WORD_W-1:0] rsp_data_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              req_beat;
   logic [CAP_W-1:0]  eff_capacity;
   logic [CNT_W-1:0]  pos_ext;
   logic              in_range;
   logic              insert_ok;
   logic [IDX_W-1:0]  insert_pos;
   logic [WORD_W-1:0] read_word;
   psl_ctrl_type      row_ctrl;

   logic [WORD_W-1:0] cell_words [LIST_DEPTH];

   // Handshakes: the response register drains while a new beat enters.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Capacity saturates at the store depth.
   assign eff_capacity = (capacity_ff > CAP_W'(LIST_DEPTH)) ? CAP_W'(LIST_DEPTH)
                                                             : capacity_ff;
   assign pos_ext      = CNT_W'(req_position);
   assign in_range     = pos_ext < count_ff;
   assign insert_ok    = ((count_ff + CNT_W'(1)) <= CNT_W'(eff_capacity))
                         && (pos_ext < CNT_W'(eff_capacity));
   // Positions past the end of the list are clamped to the end.
   assign insert_pos   = (pos_ext > count_ff) ? count_ff[IDX_W-1:0]
                                              : req_position[IDX_W-1:0];
   assign read_word    = cell_words[req_position[IDX_W-1:0]];

   // Action decode: row movement, next count and response contents.
   always_comb begin
      row_ctrl.shift = SHIFT_HOLD;
      row_ctrl.pos   = req_position[IDX_W-1:0];
      row_ctrl.word  = req_value;
      count_in       = count_ff;
      last_popped_in = last_popped_ff;
      rsp_ok_in      = 1'b0;
      rsp_data_in    = '0;
      if (req_beat) begin
         unique case (req_action)
            ACT_INSERT: begin
               if (insert_ok) begin
                  row_ctrl.shift = SHIFT_INSERT;
                  row_ctrl.pos   = insert_pos;
                  count_in       = count_ff + CNT_W'(1);
                  rsp_ok_in      = 1'b1;
               end
            end
            ACT_GET: begin
               if (in_range) begin
                  rsp_ok_in   = 1'b1;
                  rsp_data_in = read_word;
               end
            end
            ACT_POP: begin
               rsp_data_in = last_popped_ff;
               if (in_range) begin
                  row_ctrl.shift = SHIFT_POP;
                  count_in       = count_ff - CNT_W'(1);
                  last_popped_in = read_word;
                  rsp_ok_in      = 1'b1;
                  rsp_data_in    = read_word;
               end
            end
            ACT_CLEAR: begin
               count_in  = '0;
               rsp_ok_in = 1'b1;
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
      end
   end

   // Row of entry cells; the ends take zero from outside the row.
   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         logic [WORD_W-1:0] lower_word;
         logic [WORD_W-1:0] upper_word;
         if (gi == 0) begin : g_first
            assign lower_word = '0;
         end else begin : g_inner_lo
            assign lower_word = cell_words[gi-1];
         end
         if (gi == LIST_DEPTH - 1) begin : g_last
            assign upper_word = '0;
         end else begin : g_inner_hi
            assign upper_word = cell_words[gi+1];
         end
         psl_cell u_cell (
            .clock      (clock),
            .cell_index (IDX_W'(gi)),
            .ctrl       (row_ctrl),
            .lower_word (lower_word),
            .upper_word (upper_word),
            .word_out   (cell_words[gi])
         );
      end
   endgenerate

   // Response valid follows the beats in and out.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAP_RESET;
         count_ff       <= '0;
         last_popped_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         count_ff       <= count_in;
         last_popped_ff <= last_popped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_data_ff, rsp_ok_ff});

   // The count never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count beyond store depth");

   // A successful insert grows the list by one.
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_action == ACT_INSERT && insert_ok)
         |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   // A clear empties the list.
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_action == ACT_CLEAR) |=> count_ff == '0)
      else $error("clear left entries in the list");

   // A successful pop records the word that was read out.
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_action == ACT_POP && in_range)
         |=> last_popped_ff == $past(read_word) && rsp_data_ff == last_popped_ff)
      else $error("pop did not record the popped word");

   // Every accepted request leaves a response pending.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_valid_ff && rsp_count_ff == count_ff)
      else $error("request without response");

endmodule

// ----- verif/tb_positional_sequential_list_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_positional_sequential_list_top: self-checking bench for the list block
// Request beats are drawn from a queue and driven with random gaps. Each
// accepted beat is run through a shadow copy of the list, which yields the
// response that must come back. Response beats are taken with random stalls
// and compared field by field with the oldest outstanding prediction. The
// capacity is rewritten between phases, only when nothing is in flight.
// ---------------------------------------------------------------------------
module tb_positional_sequential_list_top;

   import psl_pkg::*;

   // One request and one response, unpacked into their fields.
   typedef struct packed {
      psl_action_type    action;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] value;
   } list_request_type;

   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] data;
      logic [CNT_W-1:0]  count;
   } list_response_type;

   // Clock, reset and the block's ports; the driven signals are known from time zero.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_data   = '0;

   // Stimulus, predictions and idling controls.
   list_request_type  queued_requests[$];
   list_response_type predicted_replies[$];
   list_request_type  request_on_bus;
   list_response_type reply_seen;
   list_response_type reply_wanted;
   int unsigned    sender_idle_pct   = 8;
   int unsigned    receiver_stall_pct = 72;
   int unsigned    error_count = 0;

   // Shadow copy of the list contents and of the capacity register.
   logic [WORD_W-1:0] shadow_words[LIST_DEPTH];
   int unsigned       shadow_count = 0;
   logic [WORD_W-1:0] shadow_last_popped = '0;
   logic [CAP_W-1:0]  shadow_capacity = CAP_RESET;

   positional_sequential_list_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one action to the shadow list and returns the response it causes.
   function automatic list_response_type apply_list_action(list_request_type req);
      list_response_type reply;
      int unsigned    usable_cap;
      int unsigned    slot;
      reply = '0;
      usable_cap = (shadow_capacity < LIST_DEPTH) ? shadow_capacity : LIST_DEPTH;
      case (req.action)
         ACT_INSERT: begin
            if (shadow_count + 1 <= usable_cap && req.position < usable_cap) begin
               // A position past the end is pulled back to the end.
               slot = (req.position > shadow_count) ? shadow_count : req.position;
               for (int i = shadow_count; i > slot; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[slot] = req.value;
               shadow_count++;
               reply.ok = 1'b1;
            end
         end
         ACT_GET: begin
            if (req.position < shadow_count) begin
               reply.data = shadow_words[req.position];
               reply.ok   = 1'b1;
            end
         end
         ACT_POP: begin
            // A failed pop still reports the word popped most recently.
            if (req.position < shadow_count) begin
               shadow_last_popped = shadow_words[req.position];
               for (int i = req.position + 1; i < shadow_count; i++)
                  shadow_words[i-1] = shadow_words[i];
               shadow_count--;
               reply.ok = 1'b1;
            end
            reply.data = shadow_last_popped;
         end
         default: begin
            shadow_count = 0;
            reply.ok     = 1'b1;
         end
      endcase
      reply.count = CNT_W'(shadow_count);
      return reply;
   endfunction

   // Request driver: predicts each accepted beat, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predicted_replies.push_back(apply_list_action(request_on_bus));
         if (!req_tvalid || req_tready) begin
            if (queued_requests.size() != 0 &&
                $urandom_range(99, 0) >= sender_idle_pct) begin
               request_on_bus = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, request_on_bus.value, request_on_bus.position,
                              request_on_bus.action};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
   end

   // Response monitor: every beat taken is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         reply_seen.ok    = rsp_tdata[0];
         reply_seen.data  = rsp_tdata[32:1];
         reply_seen.count = rsp_tdata[37:33];
         if (predicted_replies.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
         end else begin
            reply_wanted = predicted_replies.pop_front();
            if (reply_seen.ok !== reply_wanted.ok) begin
               $error("ok: expected %0d, got %0d", reply_wanted.ok, reply_seen.ok);
               error_count++;
            end
            if (reply_seen.data !== reply_wanted.data) begin
               $error("data: expected 0x%08h, got 0x%08h",
                      reply_wanted.data, reply_seen.data);
               error_count++;
            end
            if (reply_seen.count !== reply_wanted.count) begin
               $error("count: expected %0d, got %0d", reply_wanted.count,
                      reply_seen.count);
               error_count++;
            end
         end
      end
   end

   task automatic queue_request(psl_action_type act, logic [POS_W-1:0] pos,
                                logic [WORD_W-1:0] val);
      list_request_type req;
      req = '{action: act, position: pos, value: val};
      queued_requests.push_back(req);
   endtask

   // Random action; positions lean towards the usable part of the list.
   function automatic list_request_type random_request(int unsigned usable_cap);
      list_request_type req;
      int unsigned   pick;
      pick = $urandom_range(99, 0);
      if (pick < 45)
         req.action = ACT_INSERT;
      else if (pick < 70)
         req.action = ACT_GET;
      else if (pick < 97)
         req.action = ACT_POP;
      else
         req.action = ACT_CLEAR;
      if ($urandom_range(99, 0) < 60)
         req.position = POS_W'($urandom_range((usable_cap > 0) ? usable_cap - 1 : 0, 0));
      else
         req.position = POS_W'($urandom_range(LIST_DEPTH - 1, 0));
      pick = $urandom_range(9, 0);
      if (pick == 0)
         req.value = '0;
      else if (pick == 1)
         req.value = '1;
      else
         req.value = $urandom;
      return req;
   endfunction

   // Blocks until every queued beat has been taken and answered.
   task automatic wait_until_idle();
      while (queued_requests.size() != 0 || req_tvalid || predicted_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Capacity write, only ever issued while the list is idle.
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_capacity = cap;
   endtask

   // Stimulus sequence.
   initial begin
      logic [CAP_W-1:0] phase_caps[9];
      int unsigned      usable_cap;
      phase_caps = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd8, 5'd0, 5'd17, 5'd16, 5'd12};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty list, clamped and middle inserts, reads and pops out of range.
      queue_request(ACT_GET,    4'd0,  32'h0000_0000);
      queue_request(ACT_POP,    4'd0,  32'h0000_0000);
      queue_request(ACT_INSERT, 4'd15, 32'hFFFF_FFFF);
      queue_request(ACT_INSERT, 4'd0,  32'h0000_0000);
      queue_request(ACT_INSERT, 4'd1,  32'hA5A5_A5A5);
      queue_request(ACT_INSERT, 4'd9,  32'h5A5A_5A5A);
      queue_request(ACT_GET,    4'd0,  32'h1234_5678);
      queue_request(ACT_GET,    4'd3,  32'h0000_0000);
      queue_request(ACT_GET,    4'd4,  32'h0000_0000);
      queue_request(ACT_POP,    4'd1,  32'h0000_0000);
      queue_request(ACT_POP,    4'd15, 32'h0000_0000);
      queue_request(ACT_POP,    4'd0,  32'h0000_0000);
      queue_request(ACT_CLEAR,  4'd7,  32'hDEAD_BEEF);
      queue_request(ACT_POP,    4'd0,  32'h0000_0000);
      queue_request(ACT_GET,    4'd0,  32'h0000_0000);

      // Small capacity: fill it, then try past the end and when full.
      write_capacity(5'd2);
      queue_request(ACT_INSERT, 4'd0, 32'h1111_1111);
      queue_request(ACT_INSERT, 4'd2, 32'h2222_2222);
      queue_request(ACT_INSERT, 4'd1, 32'h3333_3333);
      queue_request(ACT_INSERT, 4'd0, 32'h4444_4444);

      // Capacity lowered below the count: entries stay readable, inserts fail until pops make room.
      write_capacity(5'd1);
      queue_request(ACT_GET,    4'd1, 32'h0000_0000);
      queue_request(ACT_INSERT, 4'd0, 32'h5555_5555);
      queue_request(ACT_POP,    4'd1, 32'h0000_0000);
      queue_request(ACT_INSERT, 4'd0, 32'h6666_6666);
      queue_request(ACT_POP,    4'd0, 32'h0000_0000);
      queue_request(ACT_INSERT, 4'd0, 32'h7777_7777);

      // Zero capacity: nothing fits, but the stored entry can still be popped.
      write_capacity(5'd0);
      queue_request(ACT_INSERT, 4'd0, 32'h8888_8888);
      queue_request(ACT_POP,    4'd0, 32'h0000_0000);

      // Random phases over a spread of capacities and idling patterns.
      for (int phase = 0; phase < 9; phase++) begin
         write_capacity(phase_caps[phase]);
         if (phase < 3) begin
            sender_idle_pct    = 8;
            receiver_stall_pct = 72;
         end else if (phase < 6) begin
            sender_idle_pct    = 72;
            receiver_stall_pct = 8;
         end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         usable_cap = (phase_caps[phase] < LIST_DEPTH) ? phase_caps[phase] : LIST_DEPTH;
         repeat (190) queued_requests.push_back(random_request(usable_cap));
      end

      wait_until_idle();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: a hung handshake or a lost response ends up here.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/psl_pkg.sv
hdl/psl_cell.sv
hdl/positional_sequential_list_top.sv
verif/tb_positional_sequential_list_top.sv
